// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the collision resolver RTL.
// Included by files that check their own pipeline behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/cbcr_pkg.sv =====
// Types, register codes and fixed-point helpers for the collision resolver.
// No dependencies; used by the collision resolver top level.
`default_nettype none
package cbcr_pkg;

   typedef struct packed {
      logic signed [31:0] circle_x;
      logic signed [31:0] circle_y;
      logic signed [31:0] circle_vx;
      logic signed [31:0] circle_vy;
      logic [30:0]        circle_diameter;
      logic [16:0]        restitution;
      logic signed [31:0] box_x;
      logic signed [31:0] box_y;
      logic [30:0]        box_side;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_vx;
      logic signed [31:0] new_vy;
      logic               contact;
      logic               came_to_rest;
   } rsp_type;

   typedef enum logic {
      CSR_REST_LIMIT = 1'b0,
      CSR_EXTRA_SEP  = 1'b1
   } csr_index_type;

   localparam logic [30:0] REST_LIMIT_RESET = 31'd655;
   localparam logic [30:0] EXTRA_SEP_RESET  = 31'd655;
   localparam int          RESTITUTION_SHIFT = 16;
   localparam int          WIDE_W = 96;

   typedef logic signed [WIDE_W-1:0] wide_type;

   function automatic wide_type shr_tz(input wide_type v, input int unsigned s);
      wide_type bias;
      bias = v[WIDE_W-1] ? ((wide_type'(1) <<< s) - wide_type'(1)) : '0;
      return (v + bias) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input wide_type v);
      wide_type max_v;
      wide_type min_v;
      max_v = {{(WIDE_W-31){1'b0}}, {31{1'b1}}};
      min_v = {{(WIDE_W-31){1'b1}}, {31{1'b0}}};
      if (v > max_v) begin
         return 32'sh7fffffff;
      end else if (v < min_v) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/circle_box_collision_resolve.sv =====
// Circle against axis-aligned square collision response, fixed point.
// Depends on cbcr_pkg, cbcr_isqrt, cbcr_div and assert_macros.svh.
//
// Usage:
//   Drive req_item and raise start; the item is taken at any clock edge
//   where start is high and busy is low. busy is always low, so one item
//   can enter every cycle.
//   Each result appears on rsp_item for exactly one cycle with rsp_valid
//   high, in input order. The receiver cannot stall the block.
//   A 31-stage square root and a FRAC_BITS+1 stage divider dominate the
//   pipeline; the rest is clamp, multiply and saturate stages. Throughput
//   is one item per cycle.
//   Registers rest_speed_limit (byte 0) and extra_separation (byte 4) are
//   written over the APB port; the user must write them only while no
//   item is in flight, and the block itself does not enforce this.
//   Reset clears every valid bit in the pipeline and loads both registers
//   with 655; items in flight are dropped.
`default_nettype none
`include "assert_macros.svh"
module circle_box_collision_resolve #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire cbcr_pkg::req_type req_item,
   output logic                   rsp_valid,
   output cbcr_pkg::rsp_type      rsp_item,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   localparam int RW   = 31;
   localparam int QW   = FRAC_BITS + 1;
   localparam int NW   = FRAC_BITS + 2;
   localparam int NUMW = 30 + FRAC_BITS;
   localparam int PW   = NW + 33;
   localparam int VW   = NW + 32;
   localparam int RFW  = NW + 35;
   localparam int ONE  = 1 << FRAC_BITS;
   localparam int LAT  = 17 + RW + QW;

   typedef struct packed {
      cbcr_pkg::req_type  req;
      logic [29:0]        radius;
      logic signed [33:0] hix;
      logic signed [33:0] lox;
      logic signed [33:0] hiy;
      logic signed [33:0] loy;
      logic signed [33:0] clx;
      logic signed [33:0] cly;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic               far;
      logic               negx;
      logic               negy;
      logic [29:0]        adx;
      logic [29:0]        ady;
      logic [59:0]        sqx;
      logic [59:0]        sqy;
      logic [63:0]        vxx;
      logic [63:0]        vyy;
      logic [61:0]        lim;
      logic [61:0]        dsq;
      logic               zero;
      logic               at_rest;
      logic [30:0]        distance;
      logic signed [31:0] overlap;
      logic               contact;
      logic signed [NW-1:0]  nx;
      logic signed [NW-1:0]  ny;
      logic [31:0]        sep;
      logic signed [PW-1:0]  px;
      logic signed [PW-1:0]  py;
      logic signed [VW-1:0]  dvx;
      logic signed [VW-1:0]  dvy;
      logic signed [VW:0]    dotraw;
      logic signed [33:0] pushx;
      logic signed [33:0] pushy;
      logic signed [31:0] posx;
      logic signed [31:0] posy;
      logic signed [33:0] dot;
      logic signed [RFW-1:0] rfx;
      logic signed [RFW-1:0] rfy;
      logic signed [34:0] tx;
      logic signed [34:0] ty;
      logic signed [35:0] rx;
      logic signed [35:0] ry;
      logic signed [53:0] rrx;
      logic signed [53:0] rry;
   } work_type;

   // configuration registers
   logic [30:0] rest_limit_ff;
   logic [30:0] extra_sep_ff;
   cbcr_pkg::csr_index_type csr_index;

   assign csr_index = cbcr_pkg::csr_index_type'(paddr[2]);
   assign pready    = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_limit_ff <= cbcr_pkg::REST_LIMIT_RESET;
         extra_sep_ff  <= cbcr_pkg::EXTRA_SEP_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (csr_index)
            cbcr_pkg::CSR_REST_LIMIT: rest_limit_ff <= pwdata[30:0];
            cbcr_pkg::CSR_EXTRA_SEP:  extra_sep_ff  <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cbcr_pkg::CSR_REST_LIMIT: prdata = {1'b0, rest_limit_ff};
         cbcr_pkg::CSR_EXTRA_SEP:  prdata = {1'b0, extra_sep_ff};
         default:                  prdata = '0;
      endcase
   end

   // pipeline registers
   work_type w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in;
   work_type w4_ff, w4_in, w5_ff, w5_in, w6_ff, w6_in, w7_ff, w7_in;
   work_type w8_ff, w8_in, w9_ff, w9_in, w10_ff, w10_in, w11_ff, w11_in;
   work_type w12_ff, w12_in, w13_ff, w13_in, w14_ff, w14_in, w15_ff, w15_in;
   work_type sbq_ff [RW];
   work_type sbd_ff [QW];
   cbcr_pkg::rsp_type rsp_ff, rsp_in;
   logic [15:0] vld_ff;
   logic [15:0] vld_in;
   logic        rsp_vld_ff;

   logic          sq_valid;
   logic [RW-1:0] sq_root;
   logic          dv_valid;
   logic          dv_valid_y;
   logic [QW-1:0] qx;
   logic [QW-1:0] qy;

   // stage 0: capture
   always_comb begin
      w0_in     = '0;
      w0_in.req = req_item;
   end

   // stage 1: square bounds
   always_comb begin
      logic signed [33:0] half;
      w1_in        = w0_ff;
      half         = $signed({4'b0, w0_ff.req.box_side[30:1]});
      w1_in.radius = w0_ff.req.circle_diameter[30:1];
      w1_in.hix    = 34'(w0_ff.req.box_x) + half;
      w1_in.lox    = 34'(w0_ff.req.box_x) - half;
      w1_in.hiy    = 34'(w0_ff.req.box_y) + half;
      w1_in.loy    = 34'(w0_ff.req.box_y) - half;
   end

   // stage 2: clamp center onto square
   always_comb begin
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      w2_in     = w1_ff;
      cx        = 34'(w1_ff.req.circle_x);
      cy        = 34'(w1_ff.req.circle_y);
      w2_in.clx = (cx < w1_ff.hix) ? cx : w1_ff.hix;
      if (w2_in.clx < w1_ff.lox) begin
         w2_in.clx = w1_ff.lox;
      end
      w2_in.cly = (cy < w1_ff.hiy) ? cy : w1_ff.hiy;
      if (w2_in.cly < w1_ff.loy) begin
         w2_in.cly = w1_ff.loy;
      end
   end

   // stage 3: offset from closest point
   always_comb begin
      w3_in    = w2_ff;
      w3_in.dx = 34'(w2_ff.req.circle_x) - w2_ff.clx;
      w3_in.dy = 34'(w2_ff.req.circle_y) - w2_ff.cly;
   end

   // stage 4: magnitudes and far test
   always_comb begin
      logic signed [33:0] ax;
      logic signed [33:0] ay;
      logic signed [33:0] rad;
      w4_in      = w3_ff;
      ax         = w3_ff.dx[33] ? -w3_ff.dx : w3_ff.dx;
      ay         = w3_ff.dy[33] ? -w3_ff.dy : w3_ff.dy;
      rad        = $signed({4'b0, w3_ff.radius});
      w4_in.far  = (ax >= rad) || (ay >= rad);
      w4_in.negx = w3_ff.dx[33];
      w4_in.negy = w3_ff.dy[33];
      w4_in.adx  = ax[29:0];
      w4_in.ady  = ay[29:0];
   end

   // stage 5: squares
   always_comb begin
      w5_in     = w4_ff;
      w5_in.sqx = 60'(w4_ff.adx) * 60'(w4_ff.adx);
      w5_in.sqy = 60'(w4_ff.ady) * 60'(w4_ff.ady);
      w5_in.vxx = $unsigned(64'(w4_ff.req.circle_vx) * 64'(w4_ff.req.circle_vx));
      w5_in.vyy = $unsigned(64'(w4_ff.req.circle_vy) * 64'(w4_ff.req.circle_vy));
      w5_in.lim = 62'(rest_limit_ff) * 62'(rest_limit_ff);
   end

   // stage 6: sums and rest test
   always_comb begin
      w6_in         = w5_ff;
      w6_in.dsq     = 62'(w5_ff.sqx) + 62'(w5_ff.sqy);
      w6_in.zero    = (w6_in.dsq == '0);
      w6_in.at_rest = (w5_ff.vxx + w5_ff.vyy) < 64'(w5_ff.lim);
   end

   cbcr_isqrt #(
      .RootW (RW)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[6]),
      .radicand  (w6_ff.dsq),
      .out_valid (sq_valid),
      .root      (sq_root)
   );

   // stage 7: distance, overlap
   always_comb begin
      work_type s;
      s              = sbq_ff[RW-1];
      w7_in          = s;
      w7_in.distance = s.zero ? 31'(ONE) : sq_root;
      w7_in.adx      = s.zero ? 30'(ONE) : s.adx;
      w7_in.ady      = s.zero ? '0 : s.ady;
      w7_in.negx     = s.zero ? 1'b0 : s.negx;
      w7_in.negy     = s.zero ? 1'b0 : s.negy;
      w7_in.overlap  = $signed({2'b0, s.radius}) - $signed({1'b0, w7_in.distance});
      w7_in.contact  = !s.far && (w7_in.overlap > 0);
   end

   cbcr_div #(
      .QuoW (QW),
      .NumW (NUMW),
      .DenW (31)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[7]),
      .numer     ({w7_ff.adx, {FRAC_BITS{1'b0}}}),
      .denom     (w7_ff.distance),
      .out_valid (dv_valid),
      .quot      (qx)
   );

   cbcr_div #(
      .QuoW (QW),
      .NumW (NUMW),
      .DenW (31)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[7]),
      .numer     ({w7_ff.ady, {FRAC_BITS{1'b0}}}),
      .denom     (w7_ff.distance),
      .out_valid (dv_valid_y),
      .quot      (qy)
   );

   // stage 8: signed normal, separation
   always_comb begin
      work_type s;
      s        = sbd_ff[QW-1];
      w8_in    = s;
      w8_in.nx = s.negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      w8_in.ny = s.negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      w8_in.sep = $unsigned(s.overlap) + {1'b0, extra_sep_ff};
   end

   // stage 9: products
   always_comb begin
      w9_in     = w8_ff;
      w9_in.px  = PW'(w8_ff.nx) * PW'($signed({1'b0, w8_ff.sep}));
      w9_in.py  = PW'(w8_ff.ny) * PW'($signed({1'b0, w8_ff.sep}));
      w9_in.dvx = VW'(w8_ff.req.circle_vx) * VW'(w8_ff.nx);
      w9_in.dvy = VW'(w8_ff.req.circle_vy) * VW'(w8_ff.ny);
   end

   // stage 10: dot sum, push amounts
   always_comb begin
      w10_in        = w9_ff;
      w10_in.dotraw = (VW+1)'(w9_ff.dvx) + (VW+1)'(w9_ff.dvy);
      w10_in.pushx  = 34'(cbcr_pkg::shr_tz(cbcr_pkg::wide_type'(w9_ff.px), FRAC_BITS));
      w10_in.pushy  = 34'(cbcr_pkg::shr_tz(cbcr_pkg::wide_type'(w9_ff.py), FRAC_BITS));
   end

   // stage 11: new position, dot product
   always_comb begin
      logic signed [34:0] sx;
      logic signed [34:0] sy;
      w11_in      = w10_ff;
      sx          = 35'(w10_ff.req.circle_x) + 35'(w10_ff.pushx);
      sy          = 35'(w10_ff.req.circle_y) + 35'(w10_ff.pushy);
      w11_in.posx = cbcr_pkg::sat32(cbcr_pkg::wide_type'(sx));
      w11_in.posy = cbcr_pkg::sat32(cbcr_pkg::wide_type'(sy));
      w11_in.dot  = 34'(cbcr_pkg::shr_tz(cbcr_pkg::wide_type'(w10_ff.dotraw), FRAC_BITS));
   end

   // stage 12: reflection products
   always_comb begin
      logic signed [34:0] d2;
      w12_in     = w11_ff;
      d2         = $signed({w11_ff.dot, 1'b0});
      w12_in.rfx = RFW'(d2) * RFW'(w11_ff.nx);
      w12_in.rfy = RFW'(d2) * RFW'(w11_ff.ny);
   end

   // stage 13: rescale reflection
   always_comb begin
      w13_in    = w12_ff;
      w13_in.tx = 35'(cbcr_pkg::shr_tz(cbcr_pkg::wide_type'(w12_ff.rfx), FRAC_BITS));
      w13_in.ty = 35'(cbcr_pkg::shr_tz(cbcr_pkg::wide_type'(w12_ff.rfy), FRAC_BITS));
   end

   // stage 14: reflected velocity
   always_comb begin
      w14_in    = w13_ff;
      w14_in.rx = 36'(w13_ff.req.circle_vx) - 36'(w13_ff.tx);
      w14_in.ry = 36'(w13_ff.req.circle_vy) - 36'(w13_ff.ty);
   end

   // stage 15: restitution
   always_comb begin
      logic signed [17:0] rs;
      w15_in     = w14_ff;
      rs         = $signed({1'b0, w14_ff.req.restitution});
      w15_in.rrx = 54'(w14_ff.rx) * 54'(rs);
      w15_in.rry = 54'(w14_ff.ry) * 54'(rs);
   end

   // stage 16: select result
   always_comb begin
      logic signed [31:0] ovx;
      logic signed [31:0] ovy;
      ovx = cbcr_pkg::sat32(cbcr_pkg::shr_tz(cbcr_pkg::wide_type'(w15_ff.rrx),
                                              cbcr_pkg::RESTITUTION_SHIFT));
      ovy = cbcr_pkg::sat32(cbcr_pkg::shr_tz(cbcr_pkg::wide_type'(w15_ff.rry),
                                              cbcr_pkg::RESTITUTION_SHIFT));
      rsp_in.new_x        = w15_ff.req.circle_x;
      rsp_in.new_y        = w15_ff.req.circle_y;
      rsp_in.new_vx       = w15_ff.req.circle_vx;
      rsp_in.new_vy       = w15_ff.req.circle_vy;
      rsp_in.contact      = 1'b0;
      rsp_in.came_to_rest = 1'b0;
      if (w15_ff.contact) begin
         rsp_in.new_x   = w15_ff.posx;
         rsp_in.new_y   = w15_ff.posy;
         rsp_in.contact = 1'b1;
         if (w15_ff.at_rest) begin
            rsp_in.new_vx       = '0;
            rsp_in.new_vy       = '0;
            rsp_in.came_to_rest = 1'b1;
         end else begin
            rsp_in.new_vx = ovx;
            rsp_in.new_vy = ovy;
         end
      end
   end

   always_comb begin
      vld_in     = '0;
      vld_in[0]  = start && !busy;
      vld_in[1]  = vld_ff[0];
      vld_in[2]  = vld_ff[1];
      vld_in[3]  = vld_ff[2];
      vld_in[4]  = vld_ff[3];
      vld_in[5]  = vld_ff[4];
      vld_in[6]  = vld_ff[5];
      vld_in[7]  = sq_valid;
      vld_in[8]  = dv_valid;
      vld_in[9]  = vld_ff[8];
      vld_in[10] = vld_ff[9];
      vld_in[11] = vld_ff[10];
      vld_in[12] = vld_ff[11];
      vld_in[13] = vld_ff[12];
      vld_in[14] = vld_ff[13];
      vld_in[15] = vld_ff[14];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= vld_ff[15];
      end
   end

   always_ff @(posedge clock) begin
      w0_ff  <= w0_in;
      w1_ff  <= w1_in;
      w2_ff  <= w2_in;
      w3_ff  <= w3_in;
      w4_ff  <= w4_in;
      w5_ff  <= w5_in;
      w6_ff  <= w6_in;
      w7_ff  <= w7_in;
      w8_ff  <= w8_in;
      w9_ff  <= w9_in;
      w10_ff <= w10_in;
      w11_ff <= w11_in;
      w12_ff <= w12_in;
      w13_ff <= w13_in;
      w14_ff <= w14_in;
      w15_ff <= w15_in;
      rsp_ff <= rsp_in;
      sbq_ff[0] <= w6_ff;
      for (int i = 1; i < RW; i++) begin
         sbq_ff[i] <= sbq_ff[i-1];
      end
      sbd_ff[0] <= w7_ff;
      for (int i = 1; i < QW; i++) begin
         sbd_ff[i] <= sbd_ff[i-1];
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_IMPLY(a_latency, clock, reset, start && !busy, ##LAT rsp_valid)
   `ASSERT_IMPLY(a_rest_zeroes, clock, reset, rsp_valid && rsp_item.came_to_rest,
                 rsp_item.contact && rsp_item.new_vx == 0 && rsp_item.new_vy == 0)
   `ASSERT_NEXT(a_sq_to_div, clock, reset, sq_valid, vld_ff[7])
   `ASSERT_IMPLY(a_div_lockstep, clock, reset, 1'b1, dv_valid_y == dv_valid)

endmodule
`default_nettype wire

// ===== hdl/cbcr_isqrt.sv =====
// Pipelined floor square root, one root bit per stage.
// Standalone; instantiated by the collision resolver top level.
`default_nettype none
module cbcr_isqrt #(
   parameter int RootW = 31
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [2*RootW-1:0]   radicand,
   output logic                      out_valid,
   output logic [RootW-1:0]          root
);
   localparam int SqW = 2*RootW;

   logic [SqW-1:0]   rem_ff  [RootW];
   logic [RootW-1:0] root_ff [RootW];
   logic             vld_ff  [RootW];

   genvar k;
   for (k = 0; k < RootW; k++) begin : g_stage
      localparam int Bit = RootW-1-k;
      logic [SqW-1:0]   rem_prev;
      logic [SqW-1:0]   trial;
      logic [SqW-1:0]   rem_in;
      logic [RootW-1:0] root_prev;
      logic [RootW-1:0] root_in;
      logic             vld_prev;

      if (k == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      always_comb begin
         trial   = (SqW'(root_prev) << (Bit+1)) + (SqW'(1) << (2*Bit));
         rem_in  = rem_prev;
         root_in = root_prev;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (RootW'(1) << Bit);
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end
   end

   assign out_valid = vld_ff[RootW-1];
   assign root      = root_ff[RootW-1];

endmodule
`default_nettype wire

// ===== hdl/cbcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; the quotient must fit in QuoW bits.
`default_nettype none
module cbcr_div #(
   parameter int QuoW = 17,
   parameter int NumW = 46,
   parameter int DenW = 31
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [NumW-1:0]  numer,
   input  wire logic [DenW-1:0]  denom,
   output logic                  out_valid,
   output logic [QuoW-1:0]       quot
);
   localparam int RemW = DenW + QuoW;

   logic [RemW-1:0] rem_ff [QuoW];
   logic [DenW-1:0] den_ff [QuoW];
   logic [QuoW-1:0] quo_ff [QuoW];
   logic            vld_ff [QuoW];

   genvar k;
   for (k = 0; k < QuoW; k++) begin : g_stage
      localparam int Bit = QuoW-1-k;
      logic [RemW-1:0] rem_prev;
      logic [RemW-1:0] sub;
      logic [RemW-1:0] rem_in;
      logic [DenW-1:0] den_prev;
      logic [QuoW-1:0] quo_prev;
      logic [QuoW-1:0] quo_in;
      logic            vld_prev;

      if (k == 0) begin : g_first
         assign rem_prev = RemW'(numer);
         assign den_prev = denom;
         assign quo_prev = '0;
         assign vld_prev = in_valid;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign vld_prev = vld_ff[k-1];
      end

      always_comb begin
         sub    = RemW'(den_prev) << Bit;
         rem_in = rem_prev;
         quo_in = quo_prev;
         if (rem_prev >= sub) begin
            rem_in = rem_prev - sub;
            quo_in = quo_prev | (QuoW'(1) << Bit);
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_prev;
         quo_ff[k] <= quo_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end
   end

   assign out_valid = vld_ff[QuoW-1];
   assign quot      = quo_ff[QuoW-1];

endmodule
`default_nettype wire
